// ===== rtl/pdl_pkg.sv =====
package pdl_pkg;

  // most prime divisors reported for one number
  localparam int MAX_RESULTS = 6;

  typedef logic [2:0] count_t;
  typedef logic [3:0] step_t;

  // microprogram step addresses
  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_TOP      = 4'd1;
  localparam step_t S_DIV_A    = 4'd2;
  localparam step_t S_WAIT_A   = 4'd3;
  localparam step_t S_TEST_SQ  = 4'd4;
  localparam step_t S_TEST_REM = 4'd5;
  localparam step_t S_EMIT_D   = 4'd6;
  localparam step_t S_REDUCE   = 4'd7;
  localparam step_t S_DIV_B    = 4'd8;
  localparam step_t S_WAIT_B   = 4'd9;
  localparam step_t S_TEST_B   = 4'd10;
  localparam step_t S_NEXT_D   = 4'd11;
  localparam step_t S_COF      = 4'd12;
  localparam step_t S_EMIT_R   = 4'd13;
  localparam step_t S_WAIT_OUT = 4'd14;
  localparam step_t S_FINISH   = 4'd15;

  // jump conditions of a control word
  typedef enum logic [3:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_DIV_BUSY,
    COND_COUNT_FULL,
    COND_D_GT_Q,
    COND_REM_NZ,
    COND_REM_Z,
    COND_COF_SKIP,
    COND_EMIT_WAIT,
    COND_FINAL_WAIT
  } cond_t;

  // one control word of the program
  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  load_in;
    logic  div_start;
    logic  rest_from_q;
    logic  d_inc;
    logic  emit;
    logic  emit_src_rest;
    logic  finish;
  } uword_t;

  // status from the datapath, tested by jump conditions
  typedef struct packed {
    logic no_input;
    logic div_busy;
    logic count_full;
    logic d_gt_q;
    logic rem_nz;
    logic cof_skip;
    logic emit_wait;
    logic final_wait;
  } flags_t;

  // datapath strobes from the sequencer
  typedef struct packed {
    logic idle;
    logic load_in;
    logic div_start;
    logic rest_from_q;
    logic d_inc;
    logic emit;
    logic emit_src_rest;
    logic finish;
  } ctl_t;

  function automatic uword_t uw(cond_t c, step_t t, logic [6:0] act);
    uword_t w;
    w.cond          = c;
    w.target        = t;
    w.load_in       = act[6];
    w.div_start     = act[5];
    w.rest_from_q   = act[4];
    w.d_inc         = act[3];
    w.emit          = act[2];
    w.emit_src_rest = act[1];
    w.finish        = act[0];
    return w;
  endfunction

  // program: trial division with repeated reduction of the cofactor
  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    unique case (s)
      S_IDLE:     w = uw(COND_NO_INPUT,   S_IDLE,     7'b1000000);
      S_TOP:      w = uw(COND_COUNT_FULL, S_WAIT_OUT, 7'b0000000);
      S_DIV_A:    w = uw(COND_NONE,       S_IDLE,     7'b0100000);
      S_WAIT_A:   w = uw(COND_DIV_BUSY,   S_WAIT_A,   7'b0000000);
      S_TEST_SQ:  w = uw(COND_D_GT_Q,     S_COF,      7'b0000000);
      S_TEST_REM: w = uw(COND_REM_NZ,     S_NEXT_D,   7'b0000000);
      S_EMIT_D:   w = uw(COND_EMIT_WAIT,  S_EMIT_D,   7'b0000100);
      S_REDUCE:   w = uw(COND_NONE,       S_IDLE,     7'b0010000);
      S_DIV_B:    w = uw(COND_NONE,       S_IDLE,     7'b0100000);
      S_WAIT_B:   w = uw(COND_DIV_BUSY,   S_WAIT_B,   7'b0000000);
      S_TEST_B:   w = uw(COND_REM_Z,      S_REDUCE,   7'b0000000);
      S_NEXT_D:   w = uw(COND_ALWAYS,     S_TOP,      7'b0001000);
      S_COF:      w = uw(COND_COF_SKIP,   S_WAIT_OUT, 7'b0000000);
      S_EMIT_R:   w = uw(COND_EMIT_WAIT,  S_EMIT_R,   7'b0000110);
      S_WAIT_OUT: w = uw(COND_FINAL_WAIT, S_WAIT_OUT, 7'b0000000);
      S_FINISH:   w = uw(COND_ALWAYS,     S_IDLE,     7'b0000001);
      default:    w = uw(COND_ALWAYS,     S_IDLE,     7'b0000000);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/prime_divisor_lister_unit.sv =====
// channel  | dir | contents
// s_*      | in  | s_tdata: number
// m_*      | out | m_tdata: divisor; m_tuser: input_is_prime; m_tlast: last
//
// one number at a time; s_tready is high only while the sequencer is idle
// each trial divisor runs through the shared radix-2 divider; a number takes up to
// about sqrt(number) trials plus one emit step per divisor and a repeated
// division by each found factor; a found divisor is held one step back
// so the last word can carry tlast; the output register frees the input side;
// m_tready low stalls the program only when a second word is ready; rst is
// synchronous and clears all control
module prime_divisor_lister_unit #(
  parameter int NUMBER_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((NUMBER_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // number
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [((NUMBER_WIDTH + 7) / 8) * 8-1:0] m_tdata,  // divisor
  output logic                                    m_tuser,  // input_is_prime
  output logic                                    m_tlast
);
  import pdl_pkg::*;

  localparam int DataW = ((NUMBER_WIDTH + 7) / 8) * 8;

  typedef logic [NUMBER_WIDTH-1:0] num_t;

  ctl_t   ctl;
  flags_t flags;
  num_t   n;
  num_t   rest;
  num_t   d;
  count_t count;
  num_t   pend_div;
  logic   pend_valid;
  num_t   out_div;
  logic   out_prime;
  logic   out_last;
  logic   out_valid;
  logic   out_free;
  logic   push;
  logic   div_busy;
  num_t   quotient;
  num_t   remainder;
  num_t   emit_val;

  pdl_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  pdl_div #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.div_start),
    .dividend  (rest),
    .divisor   (d),
    .busy      (div_busy),
    .quotient  (quotient),
    .remainder (remainder)
  );

  assign out_free = !out_valid || m_tready;
  assign push     = (ctl.emit && pend_valid) || ctl.finish;
  assign emit_val = ctl.emit_src_rest ? rest : d;

  // status for the jump conditions
  always_comb begin
    flags.no_input   = !s_tvalid;
    flags.div_busy   = div_busy;
    flags.count_full = (count == count_t'(MAX_RESULTS));
    flags.d_gt_q     = (d > quotient);
    flags.rem_nz     = (remainder != '0);
    flags.cof_skip   = (rest <= num_t'(1)) || (rest == n);
    flags.emit_wait  = pend_valid && !out_free;
    flags.final_wait = !out_free;
  end

  // working registers of the search
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      n    <= s_tdata[NUMBER_WIDTH-1:0];
      rest <= s_tdata[NUMBER_WIDTH-1:0];
      d    <= num_t'(2);
    end else begin
      if (ctl.rest_from_q) begin
        rest <= quotient;
      end
      if (ctl.d_inc) begin
        d <= d + num_t'(1);
      end
    end
  end

  // found-divisor count and the held-back divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
    end else if (ctl.load_in) begin
      count      <= '0;
      pend_valid <= 1'b0;
    end else if (ctl.emit) begin
      count      <= count + count_t'(1);
      pend_valid <= 1'b1;
    end else if (ctl.finish) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      pend_div <= emit_val;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && pend_valid) begin
      out_div   <= pend_div;
      out_prime <= 1'b0;
      out_last  <= 1'b0;
    end else if (ctl.finish) begin
      out_div   <= pend_valid ? pend_div : '0;
      out_prime <= !pend_valid;
      out_last  <= 1'b1;
    end
  end

  assign s_tready = ctl.idle;
  assign m_tvalid = out_valid;
  assign m_tdata  = DataW'(out_div);
  assign m_tuser  = out_prime;
  assign m_tlast  = out_last;

  // a prime-flag word is the single, final word with a zero divisor
  a_prime_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && out_div == '0))
    else $error("prime word malformed");

  // a divisor word always carries a divisor of at least two
  a_div_min: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (out_div >= num_t'(2)))
    else $error("divisor below two");

  // no divisor is left pending while waiting for a new number
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !pend_valid)
    else $error("pending divisor at idle");

  // the divider is never restarted while running
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    ctl.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // never more divisors than the result limit
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (count < count_t'(MAX_RESULTS)))
    else $error("too many divisors");

endmodule

// ===== rtl/pdl_div.sv =====
module pdl_div #(
  parameter int NUMBER_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] dividend,
  input  logic [NUMBER_WIDTH-1:0] divisor,
  output logic                    busy,
  output logic [NUMBER_WIDTH-1:0] quotient,
  output logic [NUMBER_WIDTH-1:0] remainder
);

  localparam int CntW = $clog2(NUMBER_WIDTH + 1);

  logic [CntW-1:0]         cnt;
  logic [NUMBER_WIDTH-1:0] quo;
  logic [NUMBER_WIDTH-1:0] rem;
  logic [NUMBER_WIDTH-1:0] dsr;
  logic [NUMBER_WIDTH:0]   trial;
  logic [NUMBER_WIDTH:0]   diff;
  logic                    ge;

  // one restoring step: shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem, quo[NUMBER_WIDTH-1]};
    diff  = trial - {1'b0, dsr};
    ge    = (trial >= {1'b0, dsr});
  end

  // busy flag, cleared after the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CntW'(1)) begin
      busy <= 1'b0;
    end
  end

  // shift registers of the divider
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CntW'(NUMBER_WIDTH);
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      cnt <= cnt - CntW'(1);
      quo <= {quo[NUMBER_WIDTH-2:0], ge};
      rem <= ge ? diff[NUMBER_WIDTH-1:0] : trial[NUMBER_WIDTH-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== rtl/pdl_seq.sv =====
module pdl_seq (
  input  logic            clk,
  input  logic            rst,
  input  pdl_pkg::flags_t flags,
  output pdl_pkg::ctl_t   ctl
);
  import pdl_pkg::*;

  step_t  pc;
  step_t  pc_next;
  uword_t uw_cur;
  logic   hit;
  logic   hold;

  assign uw_cur = ucode_rom(pc);

  // condition select
  always_comb begin
    unique case (uw_cur.cond)
      COND_NONE:       hit = 1'b0;
      COND_ALWAYS:     hit = 1'b1;
      COND_NO_INPUT:   hit = flags.no_input;
      COND_DIV_BUSY:   hit = flags.div_busy;
      COND_COUNT_FULL: hit = flags.count_full;
      COND_D_GT_Q:     hit = flags.d_gt_q;
      COND_REM_NZ:     hit = flags.rem_nz;
      COND_REM_Z:      hit = !flags.rem_nz;
      COND_COF_SKIP:   hit = flags.cof_skip;
      COND_EMIT_WAIT:  hit = flags.emit_wait;
      COND_FINAL_WAIT: hit = flags.final_wait;
      default:         hit = 1'b0;
    endcase
  end

  // a step that jumps to itself is waiting and does nothing
  assign hold    = hit && (uw_cur.target == pc);
  assign pc_next = hit ? uw_cur.target : pc + step_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // strobes to the datapath
  always_comb begin
    ctl.idle          = (pc == S_IDLE);
    ctl.load_in       = uw_cur.load_in && !hold;
    ctl.div_start     = uw_cur.div_start && !hold;
    ctl.rest_from_q   = uw_cur.rest_from_q && !hold;
    ctl.d_inc         = uw_cur.d_inc && !hold;
    ctl.emit          = uw_cur.emit && !hold;
    ctl.emit_src_rest = uw_cur.emit_src_rest;
    ctl.finish        = uw_cur.finish && !hold;
  end

endmodule
